[rtl/brrsl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package brrsl_pkg;

	localparam int CATEGORY_COUNT       = 24;
	localparam int ENTRIES_PER_CATEGORY = 16;
	localparam int RUN_BITS             = 24;

	localparam int CAT_W    = 5;
	localparam int CIDX_W   = $clog2(CATEGORY_COUNT);
	localparam int ENT_W    = (ENTRIES_PER_CATEGORY > 1) ? $clog2(ENTRIES_PER_CATEGORY) : 1;
	localparam int CNT_W    = $clog2(ENTRIES_PER_CATEGORY + 1);
	localparam int DEPTH    = CATEGORY_COUNT * ENTRIES_PER_CATEGORY;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int VAL_W    = 24;
	localparam int SCALE_W  = 32;
	localparam int SHIFT_W  = 4;
	localparam int PROD_W   = VAL_W + SHIFT_W;
	localparam int USED_W   = 4;

	localparam logic [SCALE_W-1:0] UNITY       = 32'd65536;
	localparam logic [CAT_W-1:0]   NO_CATEGORY = 5'd31;
	localparam logic [CAT_W-1:0]   LIMIT_ET    = 5'd24;
	localparam logic [CAT_W-1:0]   LIMIT_PLAIN = 5'd8;

	localparam logic [11:0] GOLD_R9  = 12'd940;
	localparam logic [12:0] ETA_B0   = 13'd1000;
	localparam logic [12:0] ETA_B1   = 13'd1450;
	localparam logic [12:0] ETA_B2   = 13'd2000;
	localparam logic [12:0] ETA_B3   = 13'd2500;
	localparam logic [15:0] ET_MIN   = 16'd320;
	localparam logic [15:0] ET_33    = 16'd528;
	localparam logic [15:0] ET_35    = 16'd560;
	localparam logic [15:0] ET_39    = 16'd624;
	localparam logic [15:0] ET_40    = 16'd640;
	localparam logic [15:0] ET_43    = 16'd688;
	localparam logic [15:0] ET_45    = 16'd720;
	localparam logic [15:0] ET_50    = 16'd800;
	localparam logic [15:0] ET_55    = 16'd880;
	localparam logic [15:0] ET_58    = 16'd928;

	typedef enum logic [1:0] {
		CMD_QUERY  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NO_SETUP  = 3'd1,
		STAT_OUTSIDE   = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_STORED    = 3'd4,
		STAT_DROPPED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_MAC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             outside;
		logic [CAT_W-1:0] cat;
	} class_t;

	typedef struct packed {
		logic [RUN_BITS-1:0]     first;
		logic [RUN_BITS-1:0]     last;
		logic signed [VAL_W-1:0] scale;
		logic signed [VAL_W-1:0] error;
	} entry_t;

	typedef struct packed {
		logic             wr;
		logic             rd;
		logic [CAT_W-1:0] cat;
		logic [ENT_W-1:0] idx;
	} store_req_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		status_t            status;
		logic [CAT_W-1:0]   cat;
		logic [USED_W-1:0]  entry;
	} result_t;

endpackage

`default_nettype wire

[rtl/brrsl_classify.sv]
`timescale 1ns / 1ps
`default_nettype none

module brrsl_classify (
	input  wire logic                 et_mode,
	input  wire logic [11:0]          shower_shape,
	input  wire logic signed [12:0]   pseudorapidity,
	input  wire logic [15:0]          transverse_energy,
	output brrsl_pkg::class_t         result
);

	logic [12:0] abs_eta;
	logic [2:0]  region;
	logic        gold;
	logic [4:0]  bad_bin;
	logic [4:0]  et_cat;

	assign abs_eta = pseudorapidity[12] ? (~pseudorapidity + 13'd1) : pseudorapidity;
	assign gold    = shower_shape > brrsl_pkg::GOLD_R9;

	always_comb begin
		if (abs_eta <= brrsl_pkg::ETA_B0)      region = 3'd0;
		else if (abs_eta <= brrsl_pkg::ETA_B1) region = 3'd1;
		else if (abs_eta <= brrsl_pkg::ETA_B2) region = 3'd2;
		else if (abs_eta <= brrsl_pkg::ETA_B3) region = 3'd3;
		else                                   region = 3'd4;
	end

	always_comb begin
		if (transverse_energy < brrsl_pkg::ET_33)      bad_bin = 5'd0;
		else if (transverse_energy < brrsl_pkg::ET_39) bad_bin = 5'd1;
		else if (transverse_energy < brrsl_pkg::ET_45) bad_bin = 5'd2;
		else if (transverse_energy < brrsl_pkg::ET_50) bad_bin = 5'd3;
		else if (transverse_energy < brrsl_pkg::ET_58) bad_bin = 5'd4;
		else                                           bad_bin = 5'd5;
	end

	always_comb begin
		if (region == 3'd0 && gold) begin
			if (transverse_energy < brrsl_pkg::ET_35)      et_cat = 5'd0;
			else if (transverse_energy < brrsl_pkg::ET_43) et_cat = 5'd1;
			else if (transverse_energy < brrsl_pkg::ET_50) et_cat = 5'd2;
			else if (transverse_energy < brrsl_pkg::ET_55) et_cat = 5'd3;
			else                                           et_cat = 5'd4;
		end else if (region == 3'd0) begin
			et_cat = 5'd5 + bad_bin;
		end else if (region == 3'd1 && gold) begin
			if (transverse_energy < brrsl_pkg::ET_40)      et_cat = 5'd11;
			else if (transverse_energy < brrsl_pkg::ET_50) et_cat = 5'd12;
			else                                           et_cat = 5'd13;
		end else if (region == 3'd1) begin
			et_cat = 5'd14 + bad_bin;
		end else if (region == 3'd2) begin
			et_cat = gold ? 5'd20 : 5'd21;
		end else begin
			et_cat = gold ? 5'd22 : 5'd23;
		end
	end

	always_comb begin
		if (et_mode) begin
			result.outside = region[2] || (transverse_energy < brrsl_pkg::ET_MIN);
			result.cat     = et_cat;
		end else begin
			result.outside = region[2];
			result.cat     = {2'b00, region[1:0], gold};
		end
	end

endmodule

`default_nettype wire

[rtl/brrsl_mac.sv]
`timescale 1ns / 1ps
`default_nettype none

module brrsl_mac (
	input  wire logic signed [brrsl_pkg::VAL_W-1:0]   scale,
	input  wire logic signed [brrsl_pkg::VAL_W-1:0]   error,
	input  wire logic signed [brrsl_pkg::SHIFT_W-1:0] shift,
	output logic [brrsl_pkg::SCALE_W-1:0]             result
);

	logic signed [brrsl_pkg::PROD_W-1:0]  prod;
	logic signed [brrsl_pkg::SCALE_W-1:0] sum;

	// The widest product plus the widest scale stays well inside 32 bits,
	// so the sum never overflows and needs no saturation.
	assign prod   = brrsl_pkg::PROD_W'(shift) * brrsl_pkg::PROD_W'(error);
	assign sum    = brrsl_pkg::SCALE_W'(scale) + brrsl_pkg::SCALE_W'(prod);
	assign result = sum;

endmodule

`default_nettype wire

[rtl/brrsl_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module brrsl_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire brrsl_pkg::store_req_t         req,
	input  wire brrsl_pkg::entry_t             wr_data,
	output brrsl_pkg::entry_t                  rd_data,
	output logic [brrsl_pkg::CNT_W-1:0]        count
);

	brrsl_pkg::entry_t mem [brrsl_pkg::DEPTH];
	logic [brrsl_pkg::CNT_W-1:0] cnt_q [brrsl_pkg::CATEGORY_COUNT];

	logic                             in_range;
	logic [brrsl_pkg::CIDX_W-1:0]     cidx;
	logic [brrsl_pkg::ADDR_W-1:0]     addr;

	assign in_range = {1'b0, req.cat} < (brrsl_pkg::CAT_W + 1)'(brrsl_pkg::CATEGORY_COUNT);
	assign cidx     = req.cat[brrsl_pkg::CIDX_W-1:0];
	assign count    = in_range ? cnt_q[cidx] : '0;
	assign addr     = brrsl_pkg::ADDR_W'(cidx) * brrsl_pkg::ADDR_W'(brrsl_pkg::ENTRIES_PER_CATEGORY)
	                + brrsl_pkg::ADDR_W'(req.idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < brrsl_pkg::CATEGORY_COUNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < brrsl_pkg::CATEGORY_COUNT; i++) begin
				if (req.wr && in_range && cidx == brrsl_pkg::CIDX_W'(i)) begin
					cnt_q[i] <= cnt_q[i] + brrsl_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= wr_data;
		end
		if (req.rd) begin
			rd_data <= mem[addr];
		end
	end

endmodule

`default_nettype wire

[rtl/binned_run_range_scale_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

// Run-range scale lookup for photon categories. Append transfers fill the
// per-category entry lists, a finish transfer enables queries, and a query
// returns scale + shift_steps * error for the first entry whose run span holds
// the run, or for the last entry when none holds it and the run is past its span.
// One item is in work at a time. A query that scans reads k entries (1 to 16)
// from the single port of the entry memory, one per cycle, until a span matches
// or the list ends. An append, a finish or a rejected query loads its result in
// the decode state, a scan that finds no entry in the scan state, and any other
// query in the multiply-add state. The done state moves the result to the output
// register only once that register is free, so a stalled output delays the next
// item. The next input is taken as soon as the result sits in the output
// register. The user must write the configuration register only while the block
// is idle; the block itself does not enforce this.
module binned_run_range_scale_lookup (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_data,       // et_dependent_mode

	input  wire logic         s_tvalid,
	output logic              s_tready,
	// shower_shape, pseudorapidity, transverse_energy, run_number, shift_steps,
	// entry_category, span_first, span_last, scale_value, scale_error, zero fill
	input  wire logic [175:0] s_tdata,
	input  wire logic [1:0]   s_tuser,        // command

	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [47:0]       m_tdata,        // scale_factor, category_used, entry_used, zero fill
	output logic [2:0]        m_tuser         // status
);

	brrsl_pkg::state_t state_q, state_d;

	logic mode_q;
	logic setup_q;

	brrsl_pkg::cmd_t                      cmd_q;
	logic [11:0]                          r9_q;
	logic signed [12:0]                   eta_q;
	logic [15:0]                          et_q;
	logic [brrsl_pkg::RUN_BITS-1:0]       run_q;
	logic signed [brrsl_pkg::SHIFT_W-1:0] shift_q;
	logic [brrsl_pkg::CAT_W-1:0]          ecat_q;
	brrsl_pkg::entry_t                    wr_entry_q;

	logic [brrsl_pkg::CAT_W-1:0] cat_q;
	logic [brrsl_pkg::CNT_W-1:0] n_q;
	logic [brrsl_pkg::ENT_W-1:0] idx_q;

	brrsl_pkg::result_t res_q, res_d;
	brrsl_pkg::result_t out_q;
	logic               out_valid_q;

	brrsl_pkg::class_t          cls;
	brrsl_pkg::store_req_t      req;
	brrsl_pkg::entry_t          rd_entry;
	logic [brrsl_pkg::CNT_W-1:0] count;
	logic [brrsl_pkg::SCALE_W-1:0] mac_out;

	logic                        st_wr, st_rd;
	logic [brrsl_pkg::CAT_W-1:0] st_cat;
	logic [brrsl_pkg::ENT_W-1:0] st_idx;
	logic                        res_load, setup_set, scan_start, idx_inc, out_load;
	logic                        accept;
	logic                        run_hit, is_last;
	logic [brrsl_pkg::CAT_W-1:0] limit;
	logic                        drop;

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	brrsl_classify u_classify (
		.et_mode           (mode_q),
		.shower_shape      (r9_q),
		.pseudorapidity    (eta_q),
		.transverse_energy (et_q),
		.result            (cls)
	);

	assign st_cat = (state_q == brrsl_pkg::ST_DECODE)
	              ? ((cmd_q == brrsl_pkg::CMD_APPEND) ? ecat_q : cls.cat)
	              : cat_q;
	assign req = '{wr: st_wr, rd: st_rd, cat: st_cat, idx: st_idx};

	brrsl_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.wr_data (wr_entry_q),
		.rd_data (rd_entry),
		.count   (count)
	);

	brrsl_mac u_mac (
		.scale  (rd_entry.scale),
		.error  (rd_entry.error),
		.shift  (shift_q),
		.result (mac_out)
	);

	assign run_hit = (run_q >= rd_entry.first) && (run_q <= rd_entry.last);
	assign is_last = (brrsl_pkg::CNT_W'(idx_q) + brrsl_pkg::CNT_W'(1)) == n_q;
	assign limit   = mode_q ? brrsl_pkg::LIMIT_ET : brrsl_pkg::LIMIT_PLAIN;
	assign drop    = (ecat_q >= limit)
	              || ({1'b0, ecat_q} >= (brrsl_pkg::CAT_W + 1)'(brrsl_pkg::CATEGORY_COUNT))
	              || (count == brrsl_pkg::CNT_W'(brrsl_pkg::ENTRIES_PER_CATEGORY));

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		st_wr      = 1'b0;
		st_rd      = 1'b0;
		st_idx     = idx_q;
		res_load   = 1'b0;
		setup_set  = 1'b0;
		scan_start = 1'b0;
		idx_inc    = 1'b0;
		out_load   = 1'b0;
		res_d      = '{scale: brrsl_pkg::UNITY, status: brrsl_pkg::STAT_OK,
		               cat: brrsl_pkg::NO_CATEGORY, entry: '0};
		unique case (state_q)
			brrsl_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = brrsl_pkg::ST_DECODE;
				end
			end
			brrsl_pkg::ST_DECODE: begin
				res_load = 1'b1;
				state_d  = brrsl_pkg::ST_DONE;
				case (cmd_q)
					brrsl_pkg::CMD_QUERY: begin
						if (!setup_q) begin
							res_d.status = brrsl_pkg::STAT_NO_SETUP;
						end else if (cls.outside) begin
							res_d.status = brrsl_pkg::STAT_OUTSIDE;
						end else if (count == '0) begin
							res_d.status = brrsl_pkg::STAT_NOT_FOUND;
							res_d.cat    = cls.cat;
						end else begin
							res_load   = 1'b0;
							scan_start = 1'b1;
							st_rd      = 1'b1;
							st_idx     = '0;
							state_d    = brrsl_pkg::ST_SCAN;
						end
					end
					brrsl_pkg::CMD_APPEND: begin
						res_d.cat = ecat_q;
						if (drop) begin
							res_d.status = brrsl_pkg::STAT_DROPPED;
						end else begin
							st_wr        = 1'b1;
							st_idx       = brrsl_pkg::ENT_W'(count);
							res_d.status = brrsl_pkg::STAT_STORED;
							res_d.entry  = brrsl_pkg::USED_W'(count);
						end
					end
					brrsl_pkg::CMD_FINISH: begin
						setup_set = 1'b1;
					end
					default: begin
					end
				endcase
			end
			brrsl_pkg::ST_SCAN: begin
				if (run_hit) begin
					state_d = brrsl_pkg::ST_MAC;
				end else if (is_last) begin
					if (run_q > rd_entry.last) begin
						state_d = brrsl_pkg::ST_MAC;
					end else begin
						res_load     = 1'b1;
						res_d.status = brrsl_pkg::STAT_NOT_FOUND;
						res_d.cat    = cat_q;
						state_d      = brrsl_pkg::ST_DONE;
					end
				end else begin
					idx_inc = 1'b1;
					st_rd   = 1'b1;
					st_idx  = idx_q + brrsl_pkg::ENT_W'(1);
				end
			end
			brrsl_pkg::ST_MAC: begin
				res_load    = 1'b1;
				res_d.scale = mac_out;
				res_d.cat   = cat_q;
				res_d.entry = brrsl_pkg::USED_W'(idx_q);
				state_d     = brrsl_pkg::ST_DONE;
			end
			brrsl_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = brrsl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = brrsl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brrsl_pkg::ST_IDLE;
			mode_q      <= 1'b0;
			setup_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (setup_set) begin
				setup_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q            <= brrsl_pkg::cmd_t'(s_tuser);
			r9_q             <= s_tdata[11:0];
			eta_q            <= s_tdata[24:12];
			et_q             <= s_tdata[40:25];
			run_q            <= brrsl_pkg::RUN_BITS'(s_tdata[64:41]);
			shift_q          <= s_tdata[68:65];
			ecat_q           <= s_tdata[73:69];
			wr_entry_q.first <= brrsl_pkg::RUN_BITS'(s_tdata[97:74]);
			wr_entry_q.last  <= brrsl_pkg::RUN_BITS'(s_tdata[121:98]);
			wr_entry_q.scale <= s_tdata[145:122];
			wr_entry_q.error <= s_tdata[169:146];
		end
		if (scan_start) begin
			cat_q <= cls.cat;
			n_q   <= count;
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + brrsl_pkg::ENT_W'(1);
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.entry, out_q.cat, out_q.scale};
	assign m_tuser  = out_q.status;

endmodule

`default_nettype wire
